>>> src/lkvc_pkg.sv
package lkvc_pkg;

    localparam int KEY_BITS    = 16;
    localparam int VALUE_BITS  = 32;
    localparam int ENTRIES_DEF = 16;

    localparam int          CAP_W     = 5;
    localparam logic [4:0]  CAP_RESET = 5'd16;

    localparam int         APB_ADDR_W = 3;
    localparam int         APB_DATA_W = 32;
    localparam logic [0:0] REG_ENTRIES_IN_USE = 1'b0;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] write_value;
    } t_in_item;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
    } t_out_item;

    // Hit flag and value passed from cell to cell during the lookup cycle.
    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] value;
    } t_chain;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_HIT,
        UPD_INSERT,
        UPD_REPLACE
    } t_upd_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } t_state;

endpackage

>>> src/lru_key_value_cache_top.sv
// A result strobes on o_done in the update state, which follows the lookup state
// entered when the item is accepted. The lookup cycle compares all cells
// and the update cycle rewrites ranks, keys and values in every cell at once.
// A new item may be accepted during the update cycle of the previous one.
// Reset (synchronous, active low) empties the store and sets the capacity to 16.
// Results cannot be stalled: each is valid for the single cycle o_done is high.
module lru_key_value_cache_top #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  lkvc_pkg::t_in_item                i_cmd,
    output logic                              o_done,
    output lkvc_pkg::t_out_item               o_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lkvc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lkvc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lkvc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int COUNT_W = $clog2(ENTRIES + 1);

    lkvc_pkg::t_state                r_state;
    lkvc_pkg::t_state                n_state;
    lkvc_pkg::t_in_item              r_item;
    logic                            r_found;
    logic [RANK_W-1:0]               r_hit_rank;
    logic [lkvc_pkg::VALUE_BITS-1:0] r_hit_value;
    logic [lkvc_pkg::CAP_W-1:0]      r_capacity;
    logic [COUNT_W-1:0]              r_count;

    logic               w_accept;
    logic               w_lookup;
    logic [COUNT_W-1:0] w_cap;
    lkvc_pkg::t_upd_op  w_op;
    logic [RANK_W-1:0]  w_limit;
    logic               w_cfg_write;

    lkvc_pkg::t_chain   w_chain      [0:ENTRIES];
    logic [RANK_W-1:0]  w_chain_rank [0:ENTRIES];
    logic [ENTRIES-1:0] w_valid;
    logic [ENTRIES-1:0] w_match;

    assign pready      = 1'b1;
    assign prdata      = lkvc_pkg::APB_DATA_W'(r_capacity);
    assign w_cfg_write = psel && penable && pwrite && pready;

    assign busy     = (r_state == lkvc_pkg::ST_LOOKUP);
    assign w_accept = start && !busy;
    assign w_lookup = (r_state == lkvc_pkg::ST_LOOKUP);

    // A capacity of zero acts as one, and anything above the cell count saturates.
    always_comb begin
        if (r_capacity == '0) begin
            w_cap = COUNT_W'(1);
        end else if (int'(r_capacity) > ENTRIES) begin
            w_cap = COUNT_W'(ENTRIES);
        end else begin
            w_cap = COUNT_W'(r_capacity);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lkvc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = lkvc_pkg::ST_LOOKUP;
                end
            end
            lkvc_pkg::ST_LOOKUP: begin
                n_state = lkvc_pkg::ST_UPDATE;
            end
            lkvc_pkg::ST_UPDATE: begin
                n_state = w_accept ? lkvc_pkg::ST_LOOKUP : lkvc_pkg::ST_IDLE;
            end
            default: begin
                n_state = lkvc_pkg::ST_IDLE;
            end
        endcase
    end

    // On a put that misses with a full store, the victim is the cell ranked occupancy minus one.
    always_comb begin
        w_op    = lkvc_pkg::UPD_NONE;
        w_limit = RANK_W'(r_count - COUNT_W'(1));
        if (r_state == lkvc_pkg::ST_UPDATE) begin
            if (r_found) begin
                w_op    = lkvc_pkg::UPD_HIT;
                w_limit = r_hit_rank;
            end else if (r_item.mode == lkvc_pkg::MODE_PUT) begin
                w_op = (r_count < w_cap) ? lkvc_pkg::UPD_INSERT : lkvc_pkg::UPD_REPLACE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lkvc_pkg::ST_IDLE;
            r_capacity <= lkvc_pkg::CAP_RESET;
            r_count    <= '0;
            r_found    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_write && paddr[2] == lkvc_pkg::REG_ENTRIES_IN_USE) begin
                r_capacity <= pwdata[lkvc_pkg::CAP_W-1:0];
            end
            if (w_op == lkvc_pkg::UPD_INSERT) begin
                r_count <= r_count + COUNT_W'(1);
            end
            if (w_lookup) begin
                r_found <= w_chain[ENTRIES].hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_cmd;
        end
        if (w_lookup) begin
            r_hit_rank  <= w_chain_rank[ENTRIES];
            r_hit_value <= w_chain[ENTRIES].value;
        end
    end

    assign w_chain[0]      = '0;
    assign w_chain_rank[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lkvc_cell #(
            .ENTRIES    (ENTRIES),
            .CELL_INDEX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_lookup     (w_lookup),
            .i_item       (r_item),
            .i_op         (w_op),
            .i_limit      (w_limit),
            .i_fill_slot  (r_count),
            .i_chain      (w_chain[g]),
            .i_chain_rank (w_chain_rank[g]),
            .o_chain      (w_chain[g+1]),
            .o_chain_rank (w_chain_rank[g+1]),
            .o_valid      (w_valid[g]),
            .o_match      (w_match[g])
        );
    end

    assign o_done              = (r_state == lkvc_pkg::ST_UPDATE);
    assign o_result.hit        = r_found;
    assign o_result.read_value = (r_found && r_item.mode == lkvc_pkg::MODE_GET) ?
                                 r_hit_value : '0;

    a_count_matches_valid: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count)
    ) else $error("occupancy count differs from number of valid cells");

    a_count_bounded: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= ENTRIES
    ) else $error("occupancy count above cell count");

    a_single_match: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lkvc_pkg::ST_UPDATE) |-> $onehot0(w_match)
    ) else $error("more than one cell holds the same key");

    a_done_after_lookup: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lkvc_pkg::ST_LOOKUP) |=> o_done
    ) else $error("lookup not followed by a result");

    a_insert_grows: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_op == lkvc_pkg::UPD_INSERT) |=> (r_count == $past(r_count) + COUNT_W'(1))
    ) else $error("insert did not raise occupancy");

endmodule

>>> src/lkvc_cell.sv
module lkvc_cell #(
    parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEF,
    parameter int CELL_INDEX = 0,
    localparam int RANK_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int COUNT_W   = $clog2(ENTRIES + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_lookup,
    input  lkvc_pkg::t_in_item   i_item,
    input  lkvc_pkg::t_upd_op    i_op,
    input  logic [RANK_W-1:0]    i_limit,
    input  logic [COUNT_W-1:0]   i_fill_slot,
    input  lkvc_pkg::t_chain     i_chain,
    input  logic [RANK_W-1:0]    i_chain_rank,
    output lkvc_pkg::t_chain     o_chain,
    output logic [RANK_W-1:0]    o_chain_rank,
    output logic                 o_valid,
    output logic                 o_match
);

    logic                            r_valid;
    logic [RANK_W-1:0]               r_rank;
    logic [lkvc_pkg::KEY_BITS-1:0]   r_key;
    logic [lkvc_pkg::VALUE_BITS-1:0] r_value;
    logic                            r_match;

    logic w_match;
    logic w_target;
    logic w_age;

    assign w_match = r_valid && (r_key == i_item.key);

    // Keys are unique among valid cells, so at most one cell adds to the chain.
    always_comb begin
        o_chain      = i_chain;
        o_chain_rank = i_chain_rank;
        if (w_match) begin
            o_chain.hit   = 1'b1;
            o_chain.value = i_chain.value | r_value;
            o_chain_rank  = i_chain_rank | r_rank;
        end
    end

    always_comb begin
        w_target = 1'b0;
        w_age    = 1'b0;
        case (i_op)
            lkvc_pkg::UPD_HIT: begin
                w_target = r_match;
                w_age    = r_valid && !r_match && (r_rank < i_limit);
            end
            lkvc_pkg::UPD_INSERT: begin
                w_target = (i_fill_slot == COUNT_W'(CELL_INDEX));
                w_age    = r_valid && !w_target;
            end
            lkvc_pkg::UPD_REPLACE: begin
                w_target = r_valid && (r_rank == i_limit);
                w_age    = r_valid && !w_target && (r_rank < i_limit);
            end
            default: begin
                w_target = 1'b0;
                w_age    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
            r_match <= 1'b0;
        end else begin
            if (i_lookup) begin
                r_match <= w_match;
            end
            if (w_target) begin
                r_valid <= 1'b1;
                r_rank  <= '0;
            end else if (w_age) begin
                r_rank <= r_rank + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_target) begin
            if (i_op != lkvc_pkg::UPD_HIT) begin
                r_key <= i_item.key;
            end
            if (i_op != lkvc_pkg::UPD_HIT || i_item.mode == lkvc_pkg::MODE_PUT) begin
                r_value <= i_item.write_value;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_match = r_match;

endmodule

>>> sim/lru_cache_checker.sv
module lru_cache_checker
    import lkvc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  t_in_item              i_cmd,
    input  logic                  i_done,
    input  t_out_item             i_result,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    input  logic [APB_DATA_W-1:0] i_prdata,
    input  logic                  i_pready,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS = ENTRIES_DEF;

    logic [CAP_W-1:0]      capacity_reg;
    bit                    slot_valid [NUM_SLOTS];
    logic [KEY_BITS-1:0]   slot_key   [NUM_SLOTS];
    logic [VALUE_BITS-1:0] slot_value [NUM_SLOTS];
    int unsigned           slot_age   [NUM_SLOTS];
    int unsigned           fill_count;
    t_out_item             lookup_results_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Slot s becomes the most recent; every valid slot younger than s_age ages by one.
    function automatic void make_most_recent(int s, int unsigned s_age);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_valid[i] && i != s && slot_age[i] < s_age) begin
                slot_age[i]++;
            end
        end
        slot_age[s] = 0;
    endfunction

    function automatic t_out_item apply_cache_op(t_in_item op);
        t_out_item   res;
        int unsigned eff_cap;
        int          slot;
        bit          found;
        bit          got;
        int unsigned oldest;

        eff_cap = capacity_reg;
        if (eff_cap < 1) eff_cap = 1;
        if (eff_cap > NUM_SLOTS) eff_cap = NUM_SLOTS;

        found = 1'b0;
        slot  = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!found && slot_valid[i] && slot_key[i] == op.key) begin
                found = 1'b1;
                slot  = i;
            end
        end

        res.hit        = found;
        res.read_value = '0;

        if (found) begin
            if (op.mode == MODE_PUT) begin
                slot_value[slot] = op.write_value;
            end else begin
                res.read_value = slot_value[slot];
            end
            make_most_recent(slot, slot_age[slot]);
            return res;
        end

        if (op.mode == MODE_GET) return res;

        if (fill_count < eff_cap) begin
            got = 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (!got && !slot_valid[i]) begin
                    slot = i;
                    got  = 1'b1;
                end
            end
            if (got) begin
                make_most_recent(slot, NUM_SLOTS);
                slot_valid[slot] = 1'b1;
                slot_key[slot]   = op.key;
                slot_value[slot] = op.write_value;
                fill_count++;
                return res;
            end
        end

        // Full at the current capacity: reuse the least recent slot in place.
        got    = 1'b0;
        oldest = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_valid[i] && (!got || slot_age[i] > oldest)) begin
                oldest = slot_age[i];
                slot   = i;
                got    = 1'b1;
            end
        end
        if (got) begin
            slot_key[slot]   = op.key;
            slot_value[slot] = op.write_value;
            make_most_recent(slot, oldest);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;

        if (!i_rst_n) begin
            capacity_reg = CAP_RESET;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_valid[i] = 1'b0;
                slot_key[i]   = '0;
                slot_value[i] = '0;
                slot_age[i]   = 0;
            end
            fill_count = 0;
            lookup_results_q.delete();
        end else begin
            if (i_done === 1'b1) begin
                if (lookup_results_q.size() == 0) begin
                    $error("result with no item outstanding: hit %0d, read_value 0x%08h",
                           i_result.hit, i_result.read_value);
                    o_fail_count++;
                end else begin
                    want = lookup_results_q.pop_front();
                    if (i_result.hit !== want.hit) begin
                        $error("hit mismatch: expected %0d, actual %0d",
                               want.hit, i_result.hit);
                        o_fail_count++;
                    end
                    if (i_result.read_value !== want.read_value) begin
                        $error("read_value mismatch: expected 0x%08h, actual 0x%08h",
                               want.read_value, i_result.read_value);
                        o_fail_count++;
                    end
                end
            end

            if (i_start && !i_busy) begin
                lookup_results_q.push_back(apply_cache_op(i_cmd));
            end

            if (i_psel && i_penable && i_pready
                    && i_paddr[APB_ADDR_W-1:2] == REG_ENTRIES_IN_USE) begin
                if (i_pwrite) begin
                    capacity_reg = i_pwdata[CAP_W-1:0];
                end else if (i_prdata !== APB_DATA_W'(capacity_reg)) begin
                    $error("entries_in_use mismatch: expected %0d, actual %0d",
                           capacity_reg, i_prdata);
                    o_fail_count++;
                end
            end
        end
        o_pending = lookup_results_q.size();
    end

endmodule

>>> sim/tb_lru_key_value_cache_top.sv
module tb_lru_key_value_cache_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lkvc_pkg::*;

    localparam logic [0:0] REG_UNMAPPED = 1'b1;
    localparam int         NUM_PHASES   = 14;
    localparam int         PHASE_ITEMS  = 103;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start   = 1'b0;
    logic                  busy;
    t_in_item              i_cmd   = '0;
    logic                  o_done;
    t_out_item             o_result;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    fail_count;
    int                    pending;
    logic [KEY_BITS-1:0]   key_pool [40];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    lru_key_value_cache_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_done  (o_done),
        .o_result(o_result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lru_cache_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_cmd       (i_cmd),
        .i_done      (o_done),
        .i_result    (o_result),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_prdata    (prdata),
        .i_pready    (pready),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    task automatic issue_op(input logic mode, input logic [KEY_BITS-1:0] key,
                            input logic [VALUE_BITS-1:0] value);
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= {mode, key, value};
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic hold_off(input int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Stop issuing and let every outstanding lookup come back.
    task automatic drain;
        hold_off(0);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [0:0] reg_index,
                              input logic [APB_DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_capacity(input logic [APB_DATA_W-1:0] data);
        drain();
        apb_access(1'b1, REG_ENTRIES_IN_USE, data);
        apb_access(1'b0, REG_ENTRIES_IN_USE, '0);
    endtask

    task automatic random_op(input int pool_size);
        logic                  mode;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        int                    pick;

        mode = ($urandom_range(0, 99) < 55) ? MODE_PUT : MODE_GET;
        if ($urandom_range(0, 9) == 0) begin
            key = KEY_BITS'($urandom());
        end else begin
            key = key_pool[$urandom_range(0, pool_size - 1)];
        end
        pick = $urandom_range(0, 19);
        if (pick == 0) value = '0;
        else if (pick == 1) value = '1;
        else value = $urandom();
        issue_op(mode, key, value);
    endtask

    initial begin
        logic [CAP_W-1:0] cap;
        int               pool_size;
        int               sent;
        int               burst;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // Reset value read back, then lookups and updates at the key and value extremes.
        apb_access(1'b0, REG_ENTRIES_IN_USE, '0);
        issue_op(MODE_GET, 16'h0000, 32'hDEAD_BEEF);
        issue_op(MODE_PUT, 16'h0000, 32'hFFFF_FFFF);
        issue_op(MODE_PUT, 16'hFFFF, 32'h0000_0000);
        issue_op(MODE_GET, 16'h0000, 32'h0000_0000);
        issue_op(MODE_GET, 16'hFFFF, 32'hFFFF_FFFF);
        issue_op(MODE_PUT, 16'h0000, 32'h1234_5678);
        issue_op(MODE_GET, 16'h0000, 32'h0000_0000);
        issue_op(MODE_GET, 16'h1234, 32'h0000_0000);

        // Capacity dropped below occupancy: the store keeps its entries.
        set_capacity(32'd1);
        apb_access(1'b1, REG_UNMAPPED, 32'd3);
        apb_access(1'b0, REG_ENTRIES_IN_USE, '0);
        issue_op(MODE_GET, 16'hFFFF, 32'h0);
        issue_op(MODE_PUT, 16'h0005, 32'hA5A5_5A5A);
        issue_op(MODE_GET, 16'h0000, 32'h0);
        issue_op(MODE_GET, 16'h0005, 32'h0);

        // A zero capacity acts as one.
        set_capacity(32'd0);
        issue_op(MODE_PUT, 16'h0007, 32'h0000_0001);
        issue_op(MODE_GET, 16'h0007, 32'h0);
        issue_op(MODE_GET, 16'h0005, 32'h0);

        // Capacities above the store size saturate.
        set_capacity(32'hFFFF_FFFF);
        issue_op(MODE_PUT, 16'h8000, 32'h8000_0000);
        issue_op(MODE_PUT, 16'h7FFF, 32'h7FFF_FFFF);
        issue_op(MODE_GET, 16'h8000, 32'h0);
        issue_op(MODE_GET, 16'h0007, 32'h0);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       cap = 5'd16;
                1:       cap = 5'd1;
                2:       cap = 5'd0;
                3:       cap = 5'd31;
                4:       cap = 5'd2;
                5:       cap = 5'd15;
                6:       cap = 5'd17;
                7:       cap = 5'd16;
                8:       cap = 5'd4;
                default: cap = CAP_W'($urandom_range(0, 31));
            endcase
            set_capacity(($urandom() & ~32'h1F) | APB_DATA_W'(cap));

            pool_size = (cap == 0) ? 2 : ((cap > 16) ? 16 : cap);
            pool_size = pool_size + $urandom_range(1, pool_size + 4);
            foreach (key_pool[i]) key_pool[i] = KEY_BITS'($urandom());

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && sent < PHASE_ITEMS; b++) begin
                    random_op(pool_size);
                    sent++;
                end
                if (phase == 5 && sent >= PHASE_ITEMS / 2 && sent < PHASE_ITEMS / 2 + 12) begin
                    drain();
                end else if ($urandom_range(0, 3) == 0) begin
                    hold_off(0);
                end else begin
                    hold_off($urandom_range(1, 8));
                end
            end
        end

        drain();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

>>> lru_key_value_cache_top.f
src/lkvc_pkg.sv
src/lkvc_cell.sv
src/lru_key_value_cache_top.sv
sim/lru_cache_checker.sv
sim/tb_lru_key_value_cache_top.sv
